// ===== rtl/domc_pkg.sv =====
package domc_pkg;

    // Field widths of the transaction payloads.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 12;

    // Internal widths before normalization.
    // Years reach 9999 + 4095, months 15 + 3 * 4095, days 31 + 4095.
    localparam int YEAR_IW  = 15;
    localparam int MONTH_IW = 14;
    localparam int DAY_IW   = 13;
    localparam int REM_W    = 7;
    localparam int RECIP_W  = 14;
    localparam int PROD_W   = YEAR_IW + RECIP_W;

    // Period kinds.
    localparam logic [KIND_W-1:0] KIND_YEARS    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUARTERS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MONTHS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DAYS     = 3'd3;

    // Calendar constants.
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;
    localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = 5'd29;
    localparam logic [REM_W-1:0]   CENTURY_LAST  = 7'd99;

    // Divide by a constant through a scaled reciprocal. Both are exact for
    // every dividend below 2**YEAR_IW.
    localparam logic [REM_W-1:0]   DIVISOR_12  = 7'd12;
    localparam logic [REM_W-1:0]   DIVISOR_100 = 7'd100;
    localparam logic [RECIP_W-1:0] RECIP_12    = 14'd10923;
    localparam logic [RECIP_W-1:0] RECIP_100   = 14'd5243;
    localparam int                 SHIFT_12    = 17;
    localparam int                 SHIFT_100   = 19;

    typedef enum logic {
        DIV_BY_12,
        DIV_BY_100
    } div_sel_t;

    typedef struct packed {
        logic                 load;
        div_sel_t             sel;
        logic [YEAR_IW-1:0]   val;
    } div_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  base_year;
        logic [MONTH_W-1:0] base_month;
        logic [DAY_W-1:0]   base_day;
        logic [KIND_W-1:0]  period_kind;
        logic [COUNT_W-1:0] period_count;
        logic [YEAR_W-1:0]  test_year;
        logic [MONTH_W-1:0] test_month;
        logic [DAY_W-1:0]   test_day;
    } item_t;

    typedef struct packed {
        logic               matches_res;
        logic [YEAR_W-1:0]  result_year;
        logic [MONTH_W-1:0] result_month;
        logic [DAY_W-1:0]   result_day;
    } result_t;

endpackage

// ===== rtl/date_offset_match_checker_unit.sv =====
// Channel   Ports                 Direction  Transfer
// command   start, busy, item     in         start high while busy low
// result    done, result          out        done high for one cycle, no stall
//
// A transaction passes ST_MONTH_REM, ST_YEAR_LOAD and ST_YEAR_REM, then ST_WALK
// steps once per month that the day overflow walks through.
// The month-by-month walk does one subtract and compare a cycle.
// Busy rises on the cycle after start is taken and falls as done is shown.
// Reset is asynchronous and returns the sequencer to idle with no result.
// The receiver cannot stall: each result is shown for exactly one cycle.
module date_offset_match_checker_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  domc_pkg::item_t   item,
    output logic              done,
    output domc_pkg::result_t result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MONTH_REM,
        ST_YEAR_LOAD,
        ST_YEAR_REM,
        ST_WALK
    } state_t;

    state_t                             state_reg, state_next;
    logic [domc_pkg::YEAR_IW-1:0]       year_reg, year_next;
    logic [domc_pkg::MONTH_IW-1:0]      month_reg, month_next;
    logic [domc_pkg::DAY_IW-1:0]        day_reg, day_next;
    logic [domc_pkg::REM_W-1:0]         cent_rem_reg, cent_rem_next;
    logic [1:0]                         cent_reg, cent_next;
    logic [domc_pkg::YEAR_W-1:0]        test_year_reg, test_year_next;
    logic [domc_pkg::MONTH_W-1:0]       test_month_reg, test_month_next;
    logic [domc_pkg::DAY_W-1:0]         test_day_reg, test_day_next;
    logic                               done_reg, done_next;
    domc_pkg::result_t                  result_reg, result_next;

    domc_pkg::div_req_t                 div_req;
    logic [domc_pkg::YEAR_IW-1:0]       div_quo;
    logic [domc_pkg::REM_W-1:0]         div_rem;

    logic                               leap;
    logic [domc_pkg::DAY_W-1:0]         month_len;
    logic [domc_pkg::MONTH_W-1:0]       month_cur;

    domc_recip_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign month_cur = month_reg[domc_pkg::MONTH_W-1:0];

    // For the leap test the year is also tracked as its remainder by 100 and the century count mod 4.
    assign leap = ((year_reg[1:0] == 2'd0) && (cent_rem_reg != '0)) ||
                  ((cent_rem_reg == '0) && (cent_reg == 2'd0));

    always_comb
    begin
        case (month_cur)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: month_len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   month_len = 5'd30;
            domc_pkg::MONTH_FEB:
                month_len = leap ? domc_pkg::LEAP_FEB_DAYS : 5'd28;
            default:                                   month_len = 5'd31;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        cent_rem_next   = cent_rem_reg;
        cent_next       = cent_reg;
        test_year_next  = test_year_reg;
        test_month_next = test_month_reg;
        test_day_next   = test_day_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        div_req.load    = 1'b0;
        div_req.sel     = domc_pkg::DIV_BY_12;
        div_req.val     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    year_next  = domc_pkg::YEAR_IW'(item.base_year);
                    month_next = domc_pkg::MONTH_IW'(item.base_month);
                    day_next   = domc_pkg::DAY_IW'(item.base_day);
                    case (item.period_kind)
                        domc_pkg::KIND_YEARS:
                            year_next = domc_pkg::YEAR_IW'(item.base_year) +
                                        domc_pkg::YEAR_IW'(item.period_count);
                        domc_pkg::KIND_QUARTERS:
                        begin
                            month_next = domc_pkg::MONTH_IW'(item.base_month) +
                                         domc_pkg::MONTH_IW'(item.period_count) +
                                         (domc_pkg::MONTH_IW'(item.period_count) << 1);
                            day_next   = domc_pkg::DAY_IW'(item.test_day);
                        end
                        domc_pkg::KIND_MONTHS:
                            month_next = domc_pkg::MONTH_IW'(item.base_month) +
                                         domc_pkg::MONTH_IW'(item.period_count);
                        domc_pkg::KIND_DAYS:
                            day_next = domc_pkg::DAY_IW'(item.base_day) +
                                       domc_pkg::DAY_IW'(item.period_count);
                        default:
                        begin
                        end
                    endcase
                    test_year_next  = item.test_year;
                    test_month_next = item.test_month;
                    test_day_next   = item.test_day;
                    div_req.load    = 1'b1;
                    div_req.sel     = domc_pkg::DIV_BY_12;
                    div_req.val     = domc_pkg::YEAR_IW'(month_next);
                    state_next      = ST_MONTH_REM;
                end
            end
            ST_MONTH_REM:
            begin
                year_next  = year_reg + div_quo;
                month_next = domc_pkg::MONTH_IW'(div_rem);
                state_next = ST_YEAR_LOAD;
            end
            ST_YEAR_LOAD:
            begin
                div_req.load = 1'b1;
                div_req.sel  = domc_pkg::DIV_BY_100;
                div_req.val  = year_reg;
                state_next   = ST_YEAR_REM;
            end
            ST_YEAR_REM:
            begin
                cent_rem_next = div_rem;
                cent_next     = div_quo[1:0];
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                if (day_reg > domc_pkg::DAY_IW'(month_len))
                begin
                    day_next = day_reg - domc_pkg::DAY_IW'(month_len);
                    if (month_cur == domc_pkg::MONTH_LAST)
                    begin
                        month_next = '0;
                        year_next  = year_reg + 1'b1;
                        if (cent_rem_reg == domc_pkg::CENTURY_LAST)
                        begin
                            cent_rem_next = '0;
                            cent_next     = cent_reg + 1'b1;
                        end
                        else
                        begin
                            cent_rem_next = cent_rem_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
                else
                begin
                    done_next                = 1'b1;
                    result_next.result_year  = domc_pkg::YEAR_W'(year_reg);
                    result_next.result_month = month_cur;
                    result_next.result_day   = domc_pkg::DAY_W'(day_reg);
                    result_next.matches_res  =
                        (year_reg == domc_pkg::YEAR_IW'(test_year_reg)) &&
                        (month_cur == test_month_reg) &&
                        (day_reg == domc_pkg::DAY_IW'(test_day_reg));
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg       <= year_next;
        month_reg      <= month_next;
        day_reg        <= day_next;
        cent_rem_reg   <= cent_rem_next;
        cent_reg       <= cent_next;
        test_year_reg  <= test_year_next;
        test_month_reg <= test_month_next;
        test_day_reg   <= test_day_next;
        result_reg     <= result_next;
    end

endmodule

// ===== rtl/domc_recip_div.sv =====
// Divides by 12 or by 100. The product is registered at load; quotient and
// remainder are valid in the cycle after load and hold until the next load.
module domc_recip_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  domc_pkg::div_req_t                    req,
    output logic [domc_pkg::YEAR_IW-1:0]          quo,
    output logic [domc_pkg::REM_W-1:0]            rem
);

    logic [domc_pkg::YEAR_IW-1:0] val_reg;
    domc_pkg::div_sel_t           sel_reg;
    logic [domc_pkg::PROD_W-1:0]  prod_reg;
    logic [domc_pkg::RECIP_W-1:0] recip;
    logic [domc_pkg::REM_W-1:0]   divisor;

    always_comb
    begin
        case (req.sel)
            domc_pkg::DIV_BY_12:  recip = domc_pkg::RECIP_12;
            domc_pkg::DIV_BY_100: recip = domc_pkg::RECIP_100;
            default:              recip = domc_pkg::RECIP_12;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= domc_pkg::DIV_BY_12;
        end
        else if (req.load)
        begin
            sel_reg <= req.sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            val_reg  <= req.val;
            prod_reg <= domc_pkg::PROD_W'(req.val) * domc_pkg::PROD_W'(recip);
        end
    end

    always_comb
    begin
        case (sel_reg)
            domc_pkg::DIV_BY_12:
            begin
                quo     = domc_pkg::YEAR_IW'(prod_reg >> domc_pkg::SHIFT_12);
                divisor = domc_pkg::DIVISOR_12;
            end
            domc_pkg::DIV_BY_100:
            begin
                quo     = domc_pkg::YEAR_IW'(prod_reg >> domc_pkg::SHIFT_100);
                divisor = domc_pkg::DIVISOR_100;
            end
            default:
            begin
                quo     = domc_pkg::YEAR_IW'(prod_reg >> domc_pkg::SHIFT_12);
                divisor = domc_pkg::DIVISOR_12;
            end
        endcase
        rem = domc_pkg::REM_W'(val_reg - domc_pkg::YEAR_IW'(quo * domc_pkg::YEAR_IW'(divisor)));
    end

endmodule

// ===== rtl/domc_checker.sv =====
module domc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input domc_pkg::item_t   item,
    input logic              done,
    input domc_pkg::result_t result
);

    // A result always closes the transaction in the same cycle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> (!$isunknown(item) ##1 busy))
        else $error("accepted transaction was unknown or did not make the unit busy");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("unit went idle without a result");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.result_month <= domc_pkg::MONTH_LAST))
        else $error("result month not normalized");

endmodule

bind date_offset_match_checker_unit domc_checker u_domc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
